// ----- hw/rtl/depth_pixel_to_world_point_top_macros.svh -----
// ----------------------------------------------------------------------------
// Depth pixel to world point - assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_TOP_MACROS_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define DPW_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("dpw port check failed");

// next-cycle implication, off during reset
`define DPW_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("dpw port check failed");

// next-cycle implication, always active
`define DPW_ASSERT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("dpw port check failed");

`endif

// ----- hw/rtl/dpw_pkg.sv -----
// ----------------------------------------------------------------------------
// dpw_pkg
// Widths, register codes and inter-stage types of the deprojection pipe.
// ----------------------------------------------------------------------------
package dpw_pkg;

  localparam int MAG_W    = 13;  // |pixel offset|
  localparam int RAY_W    = 29;  // |ray component|, Q16
  localparam int SUM_W    = 60;  // squared norm
  localparam int NRM_W    = 30;  // norm
  localparam int NUM_W    = 54;  // divider numerator
  localparam int QUO_W    = 24;  // camera point magnitude, Q8 mm
  localparam int CAM_W    = 25;  // signed camera point
  localparam int PRD_W    = 41;  // matrix entry times camera point
  localparam int ACC_W    = 48;  // row accumulator, Q22
  localparam int FRAC     = 22;
  localparam int SQ_STEPS = 30;

  typedef enum logic [2:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_SCALE,
    REG_ROW_X,
    REG_ROW_Y,
    REG_ROW_Z
  } reg_idx_t;

  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [31:0] scale;
    logic [63:0] row_x;
    logic [63:0] row_y;
    logic [63:0] row_z;
  } cfg_t;

  typedef struct packed {
    logic [RAY_W-1:0] a_mag;
    logic [RAY_W-1:0] b_mag;
    logic             a_neg;
    logic             b_neg;
    logic [15:0]      depth;
    logic [15:0]      score;
  } ray_t;

  typedef struct packed {
    logic signed [CAM_W-1:0] px;
    logic signed [CAM_W-1:0] py;
    logic signed [CAM_W-1:0] pz;
    logic [15:0]             score;
  } cam_t;

endpackage

// ----- hw/rtl/dpw_front.sv -----
// ----------------------------------------------------------------------------
// dpw_front
// Clamp, pixel offset, ray scaling and squared norm (four stages).
// ----------------------------------------------------------------------------
module dpw_front import dpw_pkg::*; #(
  parameter int COORD_BITS = 13
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cfg_t                         cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] pixel_x,
  input  logic signed [COORD_BITS-1:0] pixel_y,
  input  logic [15:0]                  depth_mm,
  input  logic [15:0]                  score_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ray_t                         out_ray,
  output logic [SUM_W-1:0]             out_sum
);

  localparam int CLW = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;

  logic [3:0] vld;
  logic [4:0] rdy;

  assign rdy[4] = out_ready;
  for (genvar i = 0; i < 4; i++) begin : g_rdy
    assign rdy[i] = ~vld[i] | rdy[i+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (rdy[i]) vld[i] <= (i == 0) ? in_valid : vld[i-1];
      end
    end
  end

  // stage 1: clamp and offset from center
  logic signed [CLW-1:0] xe, ye, wd, hd, xc, yc;
  logic signed [14:0]    dx, dy;

  always_comb begin
    xe = CLW'(pixel_x);
    ye = CLW'(pixel_y);
    wd = $signed(CLW'(cfg.width));
    hd = $signed(CLW'(cfg.height));
    xc = (xe >= wd) ? wd - CLW'(1) : xe;
    if (xc < 0) xc = '0;
    yc = (ye >= hd) ? hd - CLW'(1) : ye;
    if (yc < 0) yc = '0;
    dx = $signed({2'b00, xc[12:0]}) - $signed({3'b000, cfg.width[12:1]});
    dy = $signed({3'b000, cfg.height[12:1]}) - $signed({2'b00, yc[12:0]});
  end

  logic [MAG_W-1:0] s1_dx, s1_dy;
  logic             s1_xn, s1_yn;
  logic [15:0]      s1_depth, s1_score;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_dx    <= dx[14] ? MAG_W'(-dx) : MAG_W'(dx);
      s1_dy    <= dy[14] ? MAG_W'(-dy) : MAG_W'(dy);
      s1_xn    <= dx[14];
      s1_yn    <= dy[14];
      s1_depth <= depth_mm;
      s1_score <= score_in;
    end
  end

  // stage 2: offset times ray scale, truncated to Q16
  logic [MAG_W+31:0] pa, pb;
  ray_t              s2_ray;

  assign pa = (MAG_W+32)'(s1_dx) * (MAG_W+32)'(cfg.scale);
  assign pb = (MAG_W+32)'(s1_dy) * (MAG_W+32)'(cfg.scale);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_ray.a_mag <= pa[MAG_W+31:16];
      s2_ray.b_mag <= pb[MAG_W+31:16];
      s2_ray.a_neg <= s1_xn;
      s2_ray.b_neg <= s1_yn;
      s2_ray.depth <= s1_depth;
      s2_ray.score <= s1_score;
    end
  end

  // stage 3: squares
  ray_t               s3_ray;
  logic [2*RAY_W-1:0] s3_sa, s3_sb;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_ray <= s2_ray;
      s3_sa  <= (2*RAY_W)'(s2_ray.a_mag) * (2*RAY_W)'(s2_ray.a_mag);
      s3_sb  <= (2*RAY_W)'(s2_ray.b_mag) * (2*RAY_W)'(s2_ray.b_mag);
    end
  end

  // stage 4: sum with the unit z component squared
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      out_ray <= s3_ray;
      out_sum <= SUM_W'(s3_sa) + SUM_W'(s3_sb) + (SUM_W'(1) << 32);
    end
  end

endmodule

// ----- hw/rtl/dpw_sqrt.sv -----
// ----------------------------------------------------------------------------
// dpw_sqrt
// Integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module dpw_sqrt import dpw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ray_t             in_ray,
  input  logic [SUM_W-1:0] in_sum,
  output logic             out_valid,
  input  logic             out_ready,
  output ray_t             out_ray,
  output logic [NRM_W-1:0] out_norm
);

  logic [SQ_STEPS-1:0] vld;
  logic [SQ_STEPS:0]   rdy;
  ray_t                ray_q  [SQ_STEPS];
  logic [SUM_W-1:0]    rem_q  [SQ_STEPS];
  logic [SUM_W-1:0]    root_q [SQ_STEPS];

  assign rdy[SQ_STEPS] = out_ready;
  assign in_ready      = rdy[0];
  assign out_valid     = vld[SQ_STEPS-1];
  assign out_ray       = ray_q[SQ_STEPS-1];
  assign out_norm      = root_q[SQ_STEPS-1][NRM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < SQ_STEPS; i++) begin
        if (rdy[i]) vld[i] <= (i == 0) ? in_valid : vld[i-1];
      end
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_stage
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2*i);
    logic [SUM_W-1:0] rem_i, root_i, trial;
    ray_t             ray_i;

    assign rdy[i] = ~vld[i] | rdy[i+1];

    if (i == 0) begin : g_head
      assign rem_i  = in_sum;
      assign root_i = '0;
      assign ray_i  = in_ray;
    end else begin : g_body
      assign rem_i  = rem_q[i-1];
      assign root_i = root_q[i-1];
      assign ray_i  = ray_q[i-1];
    end

    assign trial = root_i + BIT;

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        ray_q[i] <= ray_i;
        if (rem_i >= trial) begin
          rem_q[i]  <= rem_i - trial;
          root_q[i] <= (root_i >> 1) + BIT;
        end else begin
          rem_q[i]  <= rem_i;
          root_q[i] <= root_i >> 1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/dpw_div.sv -----
// ----------------------------------------------------------------------------
// dpw_div
// Depth times ray over norm for three lanes: numerator stage, restoring
// division one quotient bit per stage, then sign.
// ----------------------------------------------------------------------------
module dpw_div import dpw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ray_t             in_ray,
  input  logic [NRM_W-1:0] in_norm,
  output logic             out_valid,
  input  logic             out_ready,
  output cam_t             out_cam
);

  localparam int NST = QUO_W + 2;

  typedef struct packed {
    logic [2:0][NUM_W-1:0] rem;
    logic [2:0][QUO_W-1:0] quo;
    logic [NRM_W-1:0]      norm;
    logic                  a_neg;
    logic                  b_neg;
    logic [15:0]           score;
  } div_st_t;

  logic [NST-1:0] vld;
  logic [NST:0]   rdy;
  div_st_t        st_q [QUO_W+1];

  assign rdy[NST]  = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = vld[NST-1];

  for (genvar i = 0; i < NST; i++) begin : g_rdy
    assign rdy[i] = ~vld[i] | rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) vld[i] <= (i == 0) ? in_valid : vld[i-1];
      end
    end
  end

  // numerators with half the divisor for rounding
  logic [NUM_W-1:0] half, pa, pb;

  assign half = NUM_W'(in_norm >> 1);
  assign pa   = NUM_W'(in_ray.depth) * NUM_W'(in_ray.a_mag);
  assign pb   = NUM_W'(in_ray.depth) * NUM_W'(in_ray.b_mag);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st_q[0].rem[0] <= (pa << 8) + half;
      st_q[0].rem[1] <= (pb << 8) + half;
      st_q[0].rem[2] <= (NUM_W'(in_ray.depth) << 24) + half;
      st_q[0].quo    <= '0;
      st_q[0].norm   <= in_norm;
      st_q[0].a_neg  <= in_ray.a_neg;
      st_q[0].b_neg  <= in_ray.b_neg;
      st_q[0].score  <= in_ray.score;
    end
  end

  for (genvar j = 1; j <= QUO_W; j++) begin : g_step
    logic [NUM_W-1:0] dv;
    div_st_t          nx;

    assign dv = NUM_W'(st_q[j-1].norm) << (QUO_W - j);

    always_comb begin
      nx = st_q[j-1];
      for (int l = 0; l < 3; l++) begin
        if (st_q[j-1].rem[l] >= dv) begin
          nx.rem[l] = st_q[j-1].rem[l] - dv;
          nx.quo[l] = {st_q[j-1].quo[l][QUO_W-2:0], 1'b1};
        end else begin
          nx.quo[l] = {st_q[j-1].quo[l][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) st_q[j] <= nx;
    end
  end

  logic signed [CAM_W-1:0] qa, qb;

  assign qa = $signed({1'b0, st_q[QUO_W].quo[0]});
  assign qb = $signed({1'b0, st_q[QUO_W].quo[1]});

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      out_cam.px    <= st_q[QUO_W].a_neg ? -qa : qa;
      out_cam.py    <= st_q[QUO_W].b_neg ? -qb : qb;
      out_cam.pz    <= $signed({1'b0, st_q[QUO_W].quo[2]});
      out_cam.score <= st_q[QUO_W].score;
    end
  end

endmodule

// ----- hw/rtl/dpw_xform.sv -----
// ----------------------------------------------------------------------------
// dpw_xform
// Rigid transform: products, row sums with translation, round and saturate.
// ----------------------------------------------------------------------------
module dpw_xform import dpw_pkg::*; #(
  parameter int OUT_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cam_t                       in_cam,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] world_x,
  output logic signed [OUT_BITS-1:0] world_y,
  output logic signed [OUT_BITS-1:0] world_z,
  output logic [15:0]                score_out
);

  localparam int QW    = ACC_W - FRAC;
  localparam int CMP_W = ((QW > OUT_BITS) ? QW : OUT_BITS) + 1;
  localparam logic signed [CMP_W-1:0] HI = CMP_W'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
  localparam logic signed [CMP_W-1:0] LO = -HI - CMP_W'(1);

  logic [2:0] vld;
  logic [3:0] rdy;

  assign rdy[3]    = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = vld[2];

  for (genvar i = 0; i < 3; i++) begin : g_rdy
    assign rdy[i] = ~vld[i] | rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (rdy[i]) vld[i] <= (i == 0) ? in_valid : vld[i-1];
      end
    end
  end

  logic [2:0][63:0] rows;
  assign rows = {cfg.row_z, cfg.row_y, cfg.row_x};

  logic signed [PRD_W-1:0] prd [3][3];
  logic [15:0]             s1_score;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int r = 0; r < 3; r++) begin
        prd[r][0] <= PRD_W'($signed(rows[r][63:48])) * PRD_W'(in_cam.px);
        prd[r][1] <= PRD_W'($signed(rows[r][47:32])) * PRD_W'(in_cam.py);
        prd[r][2] <= PRD_W'($signed(rows[r][31:16])) * PRD_W'(in_cam.pz);
      end
      s1_score <= in_cam.score;
    end
  end

  logic signed [ACC_W-1:0] acc [3];
  logic [15:0]             s2_score;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int r = 0; r < 3; r++) begin
        acc[r] <= ACC_W'(prd[r][0]) + ACC_W'(prd[r][1]) + ACC_W'(prd[r][2])
                + (ACC_W'($signed(rows[r][15:0])) <<< FRAC)
                + (ACC_W'(1) << (FRAC - 1));
      end
      s2_score <= s1_score;
    end
  end

  function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [CMP_W-1:0] q;
    q = CMP_W'($signed(v[ACC_W-1:FRAC]));
    if (q > HI) q = HI;
    if (q < LO) q = LO;
    return OUT_BITS'(q);
  endfunction

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      world_x   <= sat(acc[0]);
      world_y   <= sat(acc[1]);
      world_z   <= sat(acc[2]);
      score_out <= s2_score;
    end
  end

endmodule

// ----- hw/rtl/depth_pixel_to_world_point_top.sv -----
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_top
// Keypoint deprojection: pixel plus depth to a world point in millimeters.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one keypoint word (pixel x, pixel y, depth, score).
//   m_axis returns one world point word (x, y, z, score) per keypoint,
//   in order.
//   cfg writes image size, ray scale and the three matrix rows; write only
//   while no keypoint is in flight. cfg_ready is always high.
// Pipeline: 4 front, 30 square root, 26 divider and 3 transform stages,
//   each registered, from accepted input word to valid output word.
// Throughput: one word per cycle while m_axis_tready is high; every stage
//   is registered and a new keypoint enters each clock unless stalled.
// Stall: each stage holds while the one after it is full and stalled, so
//   empty stages keep filling and s_axis_tready drops only once the whole
//   pipe is full. Nothing is dropped or repeated.
// Reset: rst (synchronous) empties the pipe and restores a 640x480 image,
//   the default ray scale and an identity transform.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point_top import dpw_pkg::*; #(
  parameter int COORD_BITS = 13,
  parameter int OUT_BITS   = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // pixel_x, pixel_y, depth_mm, score_in, zero pad
  input  logic [((2*COORD_BITS+39)/8)*8-1:0]     s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // world_x, world_y, world_z, score_out, zero pad
  output logic [((3*OUT_BITS+23)/8)*8-1:0]       m_axis_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [2:0]                             cfg_index,
  input  logic [63:0]                            cfg_data
);

  localparam int OUT_TW = ((3*OUT_BITS+23)/8)*8;

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= 13'd640;
      cfg.height <= 13'd480;
      cfg.scale  <= 32'd6710886;
      cfg.row_x  <= 64'h4000_0000_0000_0000;
      cfg.row_y  <= 64'h0000_4000_0000_0000;
      cfg.row_z  <= 64'h0000_0000_4000_0000;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_WIDTH:  cfg.width  <= cfg_data[12:0];
        REG_HEIGHT: cfg.height <= cfg_data[12:0];
        REG_SCALE:  cfg.scale  <= cfg_data[31:0];
        REG_ROW_X:  cfg.row_x  <= cfg_data;
        REG_ROW_Y:  cfg.row_y  <= cfg_data;
        REG_ROW_Z:  cfg.row_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                    f_valid, f_ready;
  ray_t                    f_ray;
  logic [SUM_W-1:0]        f_sum;
  logic                    q_valid, q_ready;
  ray_t                    q_ray;
  logic [NRM_W-1:0]        q_norm;
  logic                    d_valid, d_ready;
  cam_t                    d_cam;
  logic signed [OUT_BITS-1:0] wx, wy, wz;
  logic [15:0]             score;

  dpw_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .pixel_x   ($signed(s_axis_tdata[COORD_BITS-1:0])),
    .pixel_y   ($signed(s_axis_tdata[2*COORD_BITS-1:COORD_BITS])),
    .depth_mm  (s_axis_tdata[2*COORD_BITS+15:2*COORD_BITS]),
    .score_in  (s_axis_tdata[2*COORD_BITS+31:2*COORD_BITS+16]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_ray   (f_ray),
    .out_sum   (f_sum)
  );

  dpw_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_ray    (f_ray),
    .in_sum    (f_sum),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_ray   (q_ray),
    .out_norm  (q_norm)
  );

  dpw_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_ray    (q_ray),
    .in_norm   (q_norm),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_cam   (d_cam)
  );

  dpw_xform #(.OUT_BITS(OUT_BITS)) u_xform (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_cam    (d_cam),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .world_x   (wx),
    .world_y   (wy),
    .world_z   (wz),
    .score_out (score)
  );

  assign m_axis_tdata = OUT_TW'({score, wz, wy, wx});

endmodule

// ----- hw/rtl/dpw_checker.sv -----
// ----------------------------------------------------------------------------
// dpw_checker
// Port-level checks on the deprojection block, bound to the top level.
// ----------------------------------------------------------------------------
`include "depth_pixel_to_world_point_top_macros.svh"

module dpw_checker #(
  parameter int OUT_BITS = 24
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [((3*OUT_BITS+23)/8)*8-1:0]     m_axis_tdata,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready
);

  `DPW_ASSERT_ALWAYS(a_reset_empties, clk, rst, !m_axis_tvalid)
  `DPW_ASSERT_NEXT(a_stall_holds, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))
  `DPW_ASSERT_NOW(a_cfg_never_stalls, clk, rst, cfg_valid, cfg_ready)

endmodule

bind depth_pixel_to_world_point_top dpw_checker #(.OUT_BITS(OUT_BITS)) u_dpw_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);
